[rtl/core/b45_pkg.sv]
package b45_pkg;

   localparam int unsigned RADIX    = 45;
   localparam int unsigned RADIX_SQ = 2025;
   localparam int unsigned QDEPTH   = 4;

   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_UPPA   = 8'h41;
   localparam logic [7:0] CH_UPPZ   = 8'h5a;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_STAR   = 8'h2a;
   localparam logic [7:0] CH_PLUS   = 8'h2b;
   localparam logic [7:0] CH_MINUS  = 8'h2d;
   localparam logic [7:0] CH_DOT    = 8'h2e;
   localparam logic [7:0] CH_SLASH  = 8'h2f;
   localparam logic [7:0] CH_COLON  = 8'h3a;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_stream;
      logic       length_error;
   } rsp_type;

   // up to two result beats per item, r0 first
   typedef struct packed {
      logic [1:0] cnt;
      rsp_type    r0;
      rsp_type    r1;
   } push_type;

   // {hit, digit}
   function automatic logic [6:0] b45_map(input logic [7:0] c);
      logic [7:0] t;
      t = 8'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         t = c - CH_ZERO;
         return {1'b1, t[5:0]};
      end
      if (c >= CH_UPPA && c <= CH_UPPZ) begin
         t = c - CH_UPPA + 8'd10;
         return {1'b1, t[5:0]};
      end
      case (c)
         CH_SPACE:  return {1'b1, 6'd36};
         CH_DOLLAR: return {1'b1, 6'd37};
         CH_PCT:    return {1'b1, 6'd38};
         CH_STAR:   return {1'b1, 6'd39};
         CH_PLUS:   return {1'b1, 6'd40};
         CH_MINUS:  return {1'b1, 6'd41};
         CH_DOT:    return {1'b1, 6'd42};
         CH_SLASH:  return {1'b1, 6'd43};
         CH_COLON:  return {1'b1, 6'd44};
         default:   return 7'd0;
      endcase
   endfunction

endpackage

[rtl/core/b45_digit_stage.sv]
module b45_digit_stage
   import b45_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_symbol,
   input  logic       req_is_last,
   input  logic       room,
   output push_type   push
);

   logic       full_ff, full_in;
   logic [7:0] sym_ff;
   logic       last_ff;
   logic [5:0] first_ff, first_in;
   logic [5:0] second_ff, second_in;
   logic [1:0] count_ff, count_in;

   logic        advance;
   logic [6:0]  mapped;
   logic        hit;
   logic [5:0]  dig;
   logic        third;
   logic [16:0] sum3;
   logic [11:0] sum2;
   logic [5:0]  f_n, s_n;
   logic [1:0]  c_n;
   logic [1:0]  n;
   rsp_type     r0, r1;

   always_comb begin
      advance   = full_ff && room;
      req_ready = !full_ff || advance;
      full_in   = (req_valid && req_ready) ? 1'b1 : (advance ? 1'b0 : full_ff);

      mapped = b45_map(sym_ff);
      hit    = mapped[6];
      dig    = mapped[5:0];
      third  = hit && (count_ff == 2'd2);

      sum3 = 17'(first_ff) + 17'(second_ff) * 17'(RADIX) + 17'(dig) * 17'(RADIX_SQ);

      f_n = first_ff;
      s_n = second_ff;
      c_n = count_ff;
      if (hit) begin
         case (count_ff)
            2'd0: begin
               f_n = dig;
               c_n = 2'd1;
            end
            2'd1: begin
               s_n = dig;
               c_n = 2'd2;
            end
            default: begin
               f_n = 6'd0;
               s_n = 6'd0;
               c_n = 2'd0;
            end
         endcase
      end
      sum2 = 12'(f_n) + 12'(s_n) * 12'(RADIX);

      n  = 2'd0;
      r0 = '0;
      r1 = '0;
      if (third) begin
         r0 = '{data_byte: sum3[15:8], byte_valid: 1'b1, end_of_stream: 1'b0,
                length_error: 1'b0};
         r1 = '{data_byte: sum3[7:0], byte_valid: 1'b1, end_of_stream: last_ff,
                length_error: 1'b0};
         n  = 2'd2;
      end
      if (last_ff) begin
         if (c_n == 2'd2) begin
            r0 = '{data_byte: sum2[7:0], byte_valid: 1'b1, end_of_stream: 1'b1,
                   length_error: 1'b0};
            n  = 2'd1;
         end else if (c_n == 2'd1) begin
            r0 = '{data_byte: 8'd0, byte_valid: 1'b0, end_of_stream: 1'b1,
                   length_error: 1'b1};
            n  = 2'd1;
         end else if (n == 2'd0) begin
            r0 = '{data_byte: 8'd0, byte_valid: 1'b0, end_of_stream: 1'b1,
                   length_error: 1'b0};
            n  = 2'd1;
         end
         f_n = 6'd0;
         s_n = 6'd0;
         c_n = 2'd0;
      end

      first_in  = advance ? f_n : first_ff;
      second_in = advance ? s_n : second_ff;
      count_in  = advance ? c_n : count_ff;

      push.cnt = advance ? n : 2'd0;
      push.r0  = r0;
      push.r1  = r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff   <= 1'b0;
         first_ff  <= 6'd0;
         second_ff <= 6'd0;
         count_ff  <= 2'd0;
      end else begin
         full_ff   <= full_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         count_ff  <= count_in;
      end
      if (req_valid && req_ready) begin
         sym_ff  <= req_symbol;
         last_ff <= req_is_last;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("digit count out of range");
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      advance && last_ff |=> count_ff == 2'd0) else $error("digits kept after last");
   a_last_yields: assert property (@(posedge clock) disable iff (reset)
      advance && last_ff |-> push.cnt != 2'd0) else $error("last beat without result");
   a_no_work_idle: assert property (@(posedge clock) disable iff (reset)
      !advance |-> push.cnt == 2'd0) else $error("push without advance");

endmodule

[rtl/core/b45_out_queue.sv]
module b45_out_queue
   import b45_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     room,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp
);

   localparam int unsigned AW = $clog2(QDEPTH);

   rsp_type           mem_ff [QDEPTH];
   logic [AW-1:0]     wr_ff, wr_in;
   logic [AW-1:0]     rd_ff, rd_in;
   logic [AW:0]       cnt_ff, cnt_in;
   logic              pop;
   logic [AW-1:0]     wr_next;

   always_comb begin
      rsp_valid = cnt_ff != '0;
      rsp       = mem_ff[rd_ff];
      pop       = rsp_valid && rsp_ready;
      // two slots must be free once this cycle's pop has gone
      room      = (cnt_ff <= (AW+1)'(QDEPTH - 2)) ||
                  (pop && (cnt_ff == (AW+1)'(QDEPTH - 1)));
      wr_next   = wr_ff + AW'(1);
      wr_in     = wr_ff + AW'(push.cnt);
      rd_in     = pop ? rd_ff + AW'(1) : rd_ff;
      cnt_in    = cnt_ff + (AW+1)'(push.cnt) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push.cnt != 2'd0) begin
         mem_ff[wr_ff] <= push.r0;
      end
      if (push.cnt == 2'd2) begin
         mem_ff[wr_next] <= push.r1;
      end
   end

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(QDEPTH)) else $error("queue overfilled");
   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      push.cnt != 2'd0 |-> room) else $error("push without room");
   a_bad_cnt: assert property (@(posedge clock) disable iff (reset)
      push.cnt != 2'd3) else $error("bad push count");

endmodule

[rtl/core/base45_stream_decoder.sv]
// Base45 (upper-case alphabet) character stream decoder.
// req channel: one character beat (req_symbol, req_is_last) per handshake.
// Characters outside the alphabet are skipped. Every third digit yields two
// rsp beats (high byte, then low byte of the 16-bit wrapped value). The last
// character settles the leftover: a pair gives one byte, a single digit
// gives a beat with rsp_length_error set, nothing gives an empty beat. The
// final beat of each stream carries rsp_end_of_stream.
// Path: a character beat is registered at acceptance, decoded from the
// decode register and written to the result queue, which drives rsp.
// Throughput: one character per cycle, limited only by rsp: a four-beat
// result queue takes the up to two beats of each character, so a trigram
// costs two rsp beats.
// Reset clears held digits, the decode register and the queue; rsp_valid is
// low afterwards. When the receiver stalls, the queue fills, req_ready falls
// while the decode register waits for two free slots, and no beat is lost.
module base45_stream_decoder
   import b45_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_symbol,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_end_of_stream,
   output logic       rsp_length_error
);

   push_type push;
   logic     room;
   rsp_type  rsp;

   b45_digit_stage u_digit (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_symbol  (req_symbol),
      .req_is_last (req_is_last),
      .room        (room),
      .push        (push)
   );

   b45_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_data_byte     = rsp.data_byte;
   assign rsp_byte_valid    = rsp.byte_valid;
   assign rsp_end_of_stream = rsp.end_of_stream;
   assign rsp_length_error  = rsp.length_error;

endmodule

[tb/sv/tb_base45_stream_decoder.sv]
`timescale 1ns / 1ps

module tb_base45_stream_decoder;
   import b45_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int LONG_HOLD  = 60;

   localparam rsp_type NO_BEAT   = '0;
   localparam rsp_type EMPTY_END = {8'h00, 1'b0, 1'b1, 1'b0};
   localparam rsp_type LEN_ERROR = {8'h00, 1'b0, 1'b1, 1'b1};

   typedef struct packed {
      logic [7:0] sym;
      logic       last;
      logic       typed;
      logic [1:0] cnt;
      rsp_type    r0;
      rsp_type    r1;
   } beat_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_symbol = 8'h00;
   logic       req_is_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_data_byte;
   logic       rsp_byte_valid;
   logic       rsp_end_of_stream;
   logic       rsp_length_error;

   base45_stream_decoder DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_symbol        (req_symbol),
      .req_is_last       (req_is_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_end_of_stream (rsp_end_of_stream),
      .rsp_length_error  (rsp_length_error)
   );

   always #10 clock = ~clock;

   string        b45_alphabet = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ $%*+-./:";
   logic [5:0]   held_d0 = '0;
   logic [5:0]   held_d1 = '0;
   logic [1:0]   held_count = '0;
   rsp_type      beats_due [$];
   beat_row_type cur_row = '0;
   beat_row_type directed_rows [25];

   int  send_idle_pct = 0;
   int  rsp_idle_pct = 0;
   bit  hold_request = 0;
   int  hold_left = 0;
   int  idle_cycles = 0;
   int  errors = 0;
   int  chars_decoded = 0;
   int  bytes_checked = 0;
   int  streams_closed = 0;
   int  pred_n;
   rsp_type pred_hi, pred_lo, want;

   function automatic int digit_of(input logic [7:0] c);
      for (int i = 0; i < 45; i++)
         if (b45_alphabet[i] == c) return i;
      return -1;
   endfunction

   task automatic decode_symbol(input logic [7:0] sym, input logic last, output int n,
                                output rsp_type hi, output rsp_type lo);
      int d;
      int sum;
      d = digit_of(sym);
      n = 0;
      hi = NO_BEAT;
      lo = NO_BEAT;
      if (d >= 0) begin
         if (held_count == 2'd0) begin
            held_d0 = 6'(d);
            held_count = 2'd1;
         end else if (held_count == 2'd1) begin
            held_d1 = 6'(d);
            held_count = 2'd2;
         end else begin
            sum = int'(held_d0) + RADIX * int'(held_d1) + RADIX_SQ * d;
            hi = {sum[15:8], 1'b1, 1'b0, 1'b0};
            lo = {sum[7:0], 1'b1, last, 1'b0};
            n = 2;
            held_count = 2'd0;
         end
      end
      if (last) begin
         if (held_count == 2'd2) begin
            sum = int'(held_d0) + RADIX * int'(held_d1);
            hi = {sum[7:0], 1'b1, 1'b1, 1'b0};
            n = 1;
         end else if (held_count == 2'd1) begin
            hi = LEN_ERROR;
            n = 1;
         end else if (n == 0) begin
            hi = EMPTY_END;
            n = 1;
         end
         held_count = 2'd0;
      end
      if (held_count == 2'd0) begin
         held_d0 = '0;
         held_d1 = '0;
      end
   endtask

   // beat monitor: predict on req, check on rsp
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            decode_symbol(req_symbol, req_is_last, pred_n, pred_hi, pred_lo);
            if (cur_row.typed) begin
               pred_n = cur_row.cnt;
               pred_hi = cur_row.r0;
               pred_lo = cur_row.r1;
            end
            if (pred_n > 0) beats_due = {beats_due, pred_hi};
            if (pred_n > 1) beats_due = {beats_due, pred_lo};
            if (digit_of(req_symbol) >= 0) chars_decoded++;
            if (req_is_last) streams_closed++;
         end
         if (rsp_valid && rsp_ready) begin
            if (beats_due.size() == 0) begin
               $error("unexpected rsp beat: data_byte %h", rsp_data_byte);
               errors++;
            end else begin
               want = beats_due.pop_front();
               bytes_checked += want.byte_valid;
               if (rsp_data_byte !== want.data_byte) begin
                  $error("data_byte: expected %h, got %h", want.data_byte, rsp_data_byte);
                  errors++;
               end
               if (rsp_byte_valid !== want.byte_valid) begin
                  $error("byte_valid: expected %b, got %b", want.byte_valid, rsp_byte_valid);
                  errors++;
               end
               if (rsp_end_of_stream !== want.end_of_stream) begin
                  $error("end_of_stream: expected %b, got %b",
                         want.end_of_stream, rsp_end_of_stream);
                  errors++;
               end
               if (rsp_length_error !== want.length_error) begin
                  $error("length_error: expected %b, got %b",
                         want.length_error, rsp_length_error);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = LONG_HOLD;
         hold_request = 0;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic offer_beat(input beat_row_type row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      cur_row = row;
      req_valid <= 1'b1;
      req_symbol <= row.sym;
      req_is_last <= row.last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic random_streams(input int n_items);
      int taken;
      int len;
      beat_row_type row;
      taken = 0;
      while (taken < n_items) begin
         len = $urandom_range(1, 12);
         for (int k = 0; k < len; k++) begin
            row = '0;
            if ($urandom_range(99) < 85)
               row.sym = b45_alphabet[$urandom_range(44)];
            else
               row.sym = 8'($urandom_range(255));
            row.last = (k == len - 1);
            taken++;
            offer_beat(row);
         end
      end
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(negedge clock);
      while (beats_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      directed_rows = '{
         {CH_ZERO,   1'b0, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
         {CH_ZERO,   1'b0, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
         {CH_ZERO,   1'b1, 1'b1, 2'd2, rsp_type'({8'h00, 1'b1, 1'b0, 1'b0}),
                                       rsp_type'({8'h00, 1'b1, 1'b1, 1'b0})},
         {CH_COLON,  1'b0, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
         {CH_COLON,  1'b0, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
         {CH_COLON,  1'b0, 1'b1, 2'd2, rsp_type'({8'h63, 1'b1, 1'b0, 1'b0}),
                                       rsp_type'({8'hF4, 1'b1, 1'b0, 1'b0})},
         {8'h61,     1'b0, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
         {8'hFF,     1'b0, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
         {8'h00,     1'b1, 1'b1, 2'd1, EMPTY_END, NO_BEAT},
         {CH_UPPZ,   1'b0, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
         {8'h00,     1'b1, 1'b1, 2'd1, LEN_ERROR, NO_BEAT},
         {CH_NINE,   1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
         {CH_UPPA,   1'b1, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
         {CH_SPACE,  1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
         {CH_DOLLAR, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
         {CH_PCT,    1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
         {CH_STAR,   1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
         {CH_PLUS,   1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
         {CH_MINUS,  1'b1, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
         {CH_DOT,    1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
         {CH_SLASH,  1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
         {8'h7A,     1'b1, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
         {CH_COLON,  1'b1, 1'b1, 2'd1, LEN_ERROR, NO_BEAT},
         {8'h40,     1'b1, 1'b1, 2'd1, EMPTY_END, NO_BEAT},
         {8'h5B,     1'b0, 1'b1, 2'd0, NO_BEAT, NO_BEAT}
      };

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 10;
      rsp_idle_pct = 53;
      foreach (directed_rows[i]) offer_beat(directed_rows[i]);
      random_streams(280);
      drain();

      send_idle_pct = 53;
      rsp_idle_pct = 10;
      random_streams(300);
      drain();

      send_idle_pct = 0;
      rsp_idle_pct = 0;
      // long receiver stall with the sender still pushing beats
      hold_request = 1;
      random_streams(60);
      drain();
      random_streams(240);
      drain();

      $display("Ran %0d streams: %0d alphabet characters decoded, %0d data bytes checked,",
               streams_closed, chars_decoded, bytes_checked);
      $display("with sender and receiver idling, a long receiver stall and a full drain.");
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/b45_pkg.sv
rtl/core/b45_digit_stage.sv
rtl/core/b45_out_queue.sv
rtl/core/base45_stream_decoder.sv
tb/sv/tb_base45_stream_decoder.sv
